/* hw/rtl/scgg_pkg.sv */
package scgg_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned COLOR_W     = 24;
  localparam int unsigned DIM_W       = 13;
  localparam int unsigned BAND_W      = 8;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned DEN_W       = BAND_W + 1;

  localparam logic [COLOR_W-1:0] BEGIN_COLOR_RST  = 24'h0FC9F4;
  localparam logic [COLOR_W-1:0] END_COLOR_RST    = 24'hC82168;
  localparam logic [DIM_W-1:0]   FRAME_WIDTH_RST  = 13'd600;
  localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RST = 13'd400;
  localparam logic [BAND_W-1:0]  BAND_COUNT_RST   = 8'd80;

  localparam logic [MODE_W-1:0] MODE_HORIZONTAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VERTICAL   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIAGONAL   = 2'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BEGIN_COLOR   = 3'd0,
    REG_END_COLOR     = 3'd1,
    REG_FRAME_WIDTH   = 3'd2,
    REG_FRAME_HEIGHT  = 3'd3,
    REG_BAND_COUNT    = 3'd4,
    REG_GRADIENT_MODE = 3'd5
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_COMMIT,
    ST_PIXEL
  } state_t;

  typedef enum logic [2:0] {
    STEP_COL_LEN,
    STEP_ROW_LEN,
    STEP_RED,
    STEP_GREEN,
    STEP_BLUE
  } div_step_t;

  typedef struct packed {
    logic step;
    logic load;
  } raster_ctl_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              eol;
    logic              eof;
  } pixel_t;

endpackage

/* hw/rtl/scgg_stream_if.sv */
interface scgg_tick_if;
  logic valid;
  logic ready;
  logic frame_start;

  modport source (output valid, output frame_start, input ready);
  modport sink   (input valid, input frame_start, output ready);
endinterface

interface scgg_pixel_if import scgg_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] pixel_red;
  logic [CHAN_W-1:0] pixel_green;
  logic [CHAN_W-1:0] pixel_blue;
  logic              end_of_line;
  logic              end_of_frame;

  modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                  output end_of_line, output end_of_frame, input ready);
  modport sink   (input valid, input pixel_red, input pixel_green, input pixel_blue,
                  input end_of_line, input end_of_frame, output ready);
endinterface

/* hw/rtl/scgg_div.sv */
module scgg_div import scgg_pkg::*; #(
  parameter int DW = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DW-1:0]    dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [DW-1:0]    quotient
);

  localparam int CNTW = $clog2(DW + 1);

  logic [CNTW-1:0]  cnt;
  logic [DW-1:0]    quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem, quo[DW-1]};
    fits    = rem_sh >= {1'b0, divisor};
    rem_sub = rem_sh - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNTW'(1));
      if (start) begin
        cnt <= CNTW'(DW);
      end else if (cnt != '0) begin
        cnt <= cnt - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (cnt != '0) begin
      quo <= {quo[DW-2:0], fits};
      rem <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

/* hw/rtl/scgg_raster.sv */
module scgg_raster import scgg_pkg::*; #(
  parameter int CW        = 13,
  parameter int RW        = 13,
  parameter int AW        = 31,
  parameter int IW        = 17,
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  raster_ctl_t          ctl,
  input  logic [CW-1:0]        eff_w,
  input  logic [RW-1:0]        eff_h,
  input  logic [CW-1:0]        col_len_in,
  input  logic [RW-1:0]        row_len_in,
  input  logic signed [IW-1:0] inc_in  [3],
  input  logic signed [AW-1:0] base_in [3],
  output pixel_t               pix
);

  logic [CW-1:0]        cc;
  logic [RW-1:0]        rc;
  logic [CW:0]          ncb;
  logic [RW:0]          nrb;
  logic [CW-1:0]        clen;
  logic [RW-1:0]        rlen;
  logic signed [AW-1:0] acc  [3];
  logic signed [AW-1:0] base [3];
  logic signed [IW-1:0] inc  [3];

  logic [CW-1:0]        j;
  logic [RW-1:0]        i;
  logic                 hit_c;
  logic                 hit_r;
  logic                 eol;
  logic                 eof;
  logic signed [AW-1:0] acc_p  [3];
  logic signed [AW-1:0] base_p [3];
  logic [CHAN_W-1:0]    chan   [3];

  always_comb begin
    j     = cc + CW'(1);
    i     = rc + RW'(1);
    hit_c = ({1'b0, j} == ncb);
    hit_r = ({1'b0, i} == nrb);
    eol   = (j >= eff_w);
    eof   = eol && (i >= eff_h);
    for (int k = 0; k < 3; k++) begin
      acc_p[k]  = hit_c ? acc[k] + AW'(inc[k]) : acc[k];
      base_p[k] = base[k] + AW'(inc[k]);
      // saturate integer part to 0..255
      if (acc_p[k][AW-1]) begin
        chan[k] = '0;
      end else if (|acc_p[k][AW-2:FRAC_BITS+CHAN_W]) begin
        chan[k] = '1;
      end else begin
        chan[k] = acc_p[k][FRAC_BITS+CHAN_W-1:FRAC_BITS];
      end
    end
    pix.red   = chan[0];
    pix.green = chan[1];
    pix.blue  = chan[2];
    pix.eol   = eol;
    pix.eof   = eof;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cc   <= '0;
      rc   <= '0;
      ncb  <= '0;
      nrb  <= '0;
      clen <= '0;
      rlen <= '0;
      for (int k = 0; k < 3; k++) begin
        acc[k]  <= '0;
        base[k] <= '0;
        inc[k]  <= '0;
      end
    end else if (ctl.load) begin
      cc   <= '0;
      rc   <= '0;
      clen <= col_len_in;
      rlen <= row_len_in;
      ncb  <= {1'b0, col_len_in};
      nrb  <= {1'b0, row_len_in};
      for (int k = 0; k < 3; k++) begin
        acc[k]  <= base_in[k];
        base[k] <= base_in[k];
        inc[k]  <= inc_in[k];
      end
    end else if (ctl.step) begin
      if (eol) begin
        if (hit_r) begin
          nrb <= nrb + (RW+1)'(rlen);
        end
        for (int k = 0; k < 3; k++) begin
          if (hit_r) begin
            base[k] <= base_p[k];
          end
          acc[k] <= hit_r ? base_p[k] : base[k];
        end
        ncb <= {1'b0, clen};
        cc  <= '0;
        rc  <= i;
      end else begin
        cc <= j;
        if (hit_c) begin
          ncb <= ncb + (CW+1)'(clen);
        end
        for (int k = 0; k < 3; k++) begin
          acc[k] <= acc_p[k];
        end
      end
    end
  end

endmodule

/* hw/rtl/stepped_color_gradient_generator_unit.sv */
// Banded RGB gradient pattern source.
// tick (sink): one transaction per pixel. frame_start=1 restarts at the top-left
//   pixel and recomputes band lengths and per-channel increments first.
// pixel (source): one transaction per tick, RGB plus end_of_line/end_of_frame.
// cfg_write_en/cfg_index/cfg_wdata: register writes, no read-back; write only
//   while the block is idle.
// Flow: a tick with frame_start=0 gives its pixel in the output register on
//   the next cycle, one pixel per clock while the sink takes them. A tick
//   with frame_start=1 and the tick that ends a frame start a frame setup:
//   five divisions run in turn on one restoring divider, DW bits wide with
//   DW = max(counter width, 8+FRAC_BITS) (16 by default), then the raster
//   loads. tick.ready stays low during setup; a frame_start pixel goes to the
//   output register after the load, once that register is free.
// Reset: registers take their default values, raster state clears to zero
//   (black pixels until the first setup).
// Stall: a pixel waiting in the output register holds; tick.ready is low
//   while the output register is full and not being taken.
module stepped_color_gradient_generator_unit import scgg_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int FRAC_BITS  = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  scgg_tick_if.sink              tick,
  scgg_pixel_if.source           pixel
);

  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int RW   = $clog2(MAX_HEIGHT + 1);
  localparam int MAXB = (CW > RW) ? CW : RW;
  localparam int MW   = CHAN_W + FRAC_BITS;
  localparam int DW   = (MAXB > MW) ? MAXB : MW;
  localparam int IW   = MW + 1;
  localparam int AW   = FRAC_BITS + 10 + MAXB;

  logic [COLOR_W-1:0] begin_color;
  logic [COLOR_W-1:0] end_color;
  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   frame_height;
  logic [BAND_W-1:0]  band_count;
  logic [MODE_W-1:0]  gradient_mode;

  logic [CW-1:0]      eff_w;
  logic [RW-1:0]      eff_h;
  logic [MODE_W-1:0]  mode_n;

  logic [CW-1:0]      snap_w;
  logic [RW-1:0]      snap_h;
  logic [BAND_W-1:0]  snap_bc;
  logic [MODE_W-1:0]  snap_mode;
  logic [COLOR_W-1:0] snap_begin;
  logic [COLOR_W-1:0] snap_end;

  state_t    state, state_next;
  div_step_t div_step, div_step_next;
  logic      pending, pending_next;
  logic      snap;
  logic      div_start;
  logic      tick_ready;
  logic      out_free;
  raster_ctl_t ctl;

  logic [DW-1:0]    div_dividend;
  logic [DEN_W-1:0] div_divisor;
  logic [DEN_W-1:0] den;
  logic             div_done;
  logic [DW-1:0]    div_quo;

  logic [CHAN_W:0]      diff     [3];
  logic [CHAN_W-1:0]    diff_mag [3];
  logic                 diff_neg [3];
  logic [CW-1:0]        col_len_q;
  logic [RW-1:0]        row_len_q;
  logic signed [IW-1:0] inc_q    [3];
  logic signed [IW-1:0] inc_new;
  logic signed [AW-1:0] base_in  [3];
  logic [1:0]           ch_sel;

  pixel_t pix;
  pixel_t out_pix;
  logic   out_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      begin_color   <= BEGIN_COLOR_RST;
      end_color     <= END_COLOR_RST;
      frame_width   <= FRAME_WIDTH_RST;
      frame_height  <= FRAME_HEIGHT_RST;
      band_count    <= BAND_COUNT_RST;
      gradient_mode <= MODE_HORIZONTAL;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_BEGIN_COLOR:   begin_color   <= cfg_wdata[COLOR_W-1:0];
        REG_END_COLOR:     end_color     <= cfg_wdata[COLOR_W-1:0];
        REG_FRAME_WIDTH:   frame_width   <= cfg_wdata[DIM_W-1:0];
        REG_FRAME_HEIGHT:  frame_height  <= cfg_wdata[DIM_W-1:0];
        REG_BAND_COUNT:    band_count    <= cfg_wdata[BAND_W-1:0];
        REG_GRADIENT_MODE: gradient_mode <= cfg_wdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width == '0) begin
      eff_w = CW'(1);
    end else if ({1'b0, frame_width} > (DIM_W+1)'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h = RW'(1);
    end else if ({1'b0, frame_height} > (DIM_W+1)'(MAX_HEIGHT)) begin
      eff_h = RW'(MAX_HEIGHT);
    end else begin
      eff_h = RW'(frame_height);
    end
    mode_n = (gradient_mode == MODE_VERTICAL || gradient_mode == MODE_DIAGONAL) ?
             gradient_mode : MODE_HORIZONTAL;
  end

  // setup operands are frozen when the setup starts
  always_ff @(posedge clk) begin
    if (snap) begin
      snap_w     <= eff_w;
      snap_h     <= eff_h;
      snap_bc    <= band_count;
      snap_mode  <= mode_n;
      snap_begin <= begin_color;
      snap_end   <= end_color;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]     = {1'b0, snap_end[CHAN_W*(2-k) +: CHAN_W]}
                  - {1'b0, snap_begin[CHAN_W*(2-k) +: CHAN_W]};
      diff_neg[k] = diff[k][CHAN_W];
      diff_mag[k] = diff_neg[k] ? CHAN_W'(-diff[k]) : diff[k][CHAN_W-1:0];
      base_in[k]  = AW'({snap_begin[CHAN_W*(2-k) +: CHAN_W], {FRAC_BITS{1'b0}}});
    end
    den = (snap_mode == MODE_DIAGONAL) ? {snap_bc, 1'b0} : {1'b0, snap_bc};
    unique case (div_step)
      STEP_GREEN: ch_sel = 2'd1;
      STEP_BLUE:  ch_sel = 2'd2;
      default:    ch_sel = 2'd0;
    endcase
    unique case (div_step)
      STEP_COL_LEN: begin
        div_dividend = DW'(snap_w);
        div_divisor  = {1'b0, snap_bc};
      end
      STEP_ROW_LEN: begin
        div_dividend = DW'(snap_h);
        div_divisor  = {1'b0, snap_bc};
      end
      default: begin
        div_dividend = DW'({diff_mag[ch_sel], {FRAC_BITS{1'b0}}});
        div_divisor  = den;
      end
    endcase
    if (snap_bc == '0) begin
      inc_new = '0;
    end else if (diff_neg[ch_sel]) begin
      inc_new = -$signed({1'b0, div_quo[MW-1:0]});
    end else begin
      inc_new = $signed({1'b0, div_quo[MW-1:0]});
    end
  end

  scgg_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (state == ST_WAIT && div_done) begin
      unique case (div_step)
        STEP_COL_LEN: col_len_q <= (snap_bc != '0 && snap_mode != MODE_VERTICAL) ?
                                   div_quo[CW-1:0] : '0;
        STEP_ROW_LEN: row_len_q <= (snap_bc != '0 && snap_mode != MODE_HORIZONTAL) ?
                                   div_quo[RW-1:0] : '0;
        default:      inc_q[ch_sel] <= inc_new;
      endcase
    end
  end

  scgg_raster #(
    .CW        (CW),
    .RW        (RW),
    .AW        (AW),
    .IW        (IW),
    .FRAC_BITS (FRAC_BITS)
  ) u_raster (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .eff_w      (eff_w),
    .eff_h      (eff_h),
    .col_len_in (col_len_q),
    .row_len_in (row_len_q),
    .inc_in     (inc_q),
    .base_in    (base_in),
    .pix        (pix)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      div_step <= STEP_COL_LEN;
      pending  <= 1'b0;
    end else begin
      state    <= state_next;
      div_step <= div_step_next;
      pending  <= pending_next;
    end
  end

  assign out_free = !out_valid || pixel.ready;

  always_comb begin
    state_next    = state;
    div_step_next = div_step;
    pending_next  = pending;
    snap          = 1'b0;
    div_start     = 1'b0;
    tick_ready    = 1'b0;
    ctl           = '0;
    unique case (state)
      ST_IDLE: begin
        tick_ready = out_free;
        if (tick.valid && out_free) begin
          if (tick.frame_start) begin
            snap          = 1'b1;
            div_step_next = STEP_COL_LEN;
            pending_next  = 1'b1;
            state_next    = ST_START;
          end else begin
            ctl.step = 1'b1;
            if (pix.eof) begin
              snap          = 1'b1;
              div_step_next = STEP_COL_LEN;
              pending_next  = 1'b0;
              state_next    = ST_START;
            end
          end
        end
      end
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          if (div_step == STEP_BLUE) begin
            state_next = ST_COMMIT;
          end else begin
            div_step_next = div_step_t'(div_step + 3'd1);
            state_next    = ST_START;
          end
        end
      end
      ST_COMMIT: begin
        ctl.load   = 1'b1;
        state_next = pending ? ST_PIXEL : ST_IDLE;
      end
      ST_PIXEL: begin
        if (out_free) begin
          ctl.step = 1'b1;
          if (pix.eof) begin
            snap          = 1'b1;
            div_step_next = STEP_COL_LEN;
            pending_next  = 1'b0;
            state_next    = ST_START;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign tick.ready = tick_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.step) begin
      out_valid <= 1'b1;
    end else if (pixel.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      out_pix <= pix;
    end
  end

  assign pixel.valid        = out_valid;
  assign pixel.pixel_red    = out_pix.red;
  assign pixel.pixel_green  = out_pix.green;
  assign pixel.pixel_blue   = out_pix.blue;
  assign pixel.end_of_line  = out_pix.eol;
  assign pixel.end_of_frame = out_pix.eof;

endmodule

/* hw/rtl/scgg_checker.sv */
module scgg_checker (
  input logic clk,
  input logic rst,
  input logic tick_valid,
  input logic tick_ready,
  input logic tick_frame_start,
  input logic pixel_valid,
  input logic pixel_ready,
  input logic pixel_eol,
  input logic pixel_eof
);

  a_pixel_hold: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_ready) |=> pixel_valid)
    else $error("pixel transaction dropped while stalled");

  a_tick_gives_pixel: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && tick_ready && !tick_frame_start) |=> pixel_valid)
    else $error("pixel tick produced no pixel");

  a_eof_is_eol: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && pixel_eof) |-> pixel_eol)
    else $error("end of frame without end of line");

  a_stall_blocks_tick: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_ready) |-> !tick_ready)
    else $error("tick taken while output is stalled");

  a_setup_busy: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && tick_ready && tick_frame_start) |=> !tick_ready)
    else $error("tick ready during frame setup");

endmodule

bind stepped_color_gradient_generator_unit scgg_checker u_scgg_checker (
  .clk              (clk),
  .rst              (rst),
  .tick_valid       (tick.valid),
  .tick_ready       (tick.ready),
  .tick_frame_start (tick.frame_start),
  .pixel_valid      (pixel.valid),
  .pixel_ready      (pixel.ready),
  .pixel_eol        (pixel.end_of_line),
  .pixel_eof        (pixel.end_of_frame)
);

/* sim/tb_stepped_color_gradient_generator_unit.sv */
`timescale 1ns / 100ps

module tb_stepped_color_gradient_generator_unit;
  import scgg_pkg::*;

  localparam int unsigned MAX_DIM          = 4096;
  localparam int unsigned FRAC             = 8;
  localparam int unsigned DIM_ALL_ONES     = (1 << DIM_W) - 1;
  localparam int unsigned SETUP_GUARD      = 250;
  localparam int unsigned SINK_HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_TICKS     = 1200;
  localparam int unsigned CYCLE_LIMIT      = 3_000_000;
  localparam logic [MODE_W-1:0] MODE_ALIAS_HORIZONTAL = 2'd3;
  localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h000000;
  localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFFFFFF;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  scgg_tick_if  tick_ch ();
  scgg_pixel_if pix_ch ();

  stepped_color_gradient_generator_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .tick         (tick_ch),
    .pixel        (pix_ch)
  );

  // register shadow
  logic [COLOR_W-1:0] reg_begin  = BEGIN_COLOR_RST;
  logic [COLOR_W-1:0] reg_end    = END_COLOR_RST;
  logic [DIM_W-1:0]   reg_width  = FRAME_WIDTH_RST;
  logic [DIM_W-1:0]   reg_height = FRAME_HEIGHT_RST;
  logic [BAND_W-1:0]  reg_bands  = BAND_COUNT_RST;
  logic [MODE_W-1:0]  reg_mode   = MODE_HORIZONTAL;

  // raster and color state of the pattern
  logic [DIM_W-1:0] col_cnt  = '0;
  logic [DIM_W-1:0] row_cnt  = '0;
  logic [DIM_W:0]   col_mark = '0;
  logic [DIM_W:0]   row_mark = '0;
  logic [DIM_W-1:0] col_len  = '0;
  logic [DIM_W-1:0] row_len  = '0;
  longint           acc      [3] = '{0, 0, 0};
  longint           row_base [3] = '{0, 0, 0};
  longint           step_inc [3] = '{0, 0, 0};

  pixel_t      expected_pixels [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          src_jitter = 1'b1;
  bit          sink_jitter = 1'b1;
  bit          hold_sink = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v);
    if (v == 0) return DIM_W'(1);
    if (v > MAX_DIM) return DIM_W'(MAX_DIM);
    return v;
  endfunction

  function automatic logic [CHAN_W-1:0] sat_channel(longint a);
    longint q;
    if (a < 0) return '0;
    q = a >>> FRAC;
    if (q > 255) return 8'hFF;
    return q[CHAN_W-1:0];
  endfunction

  function automatic void load_frame();
    logic [MODE_W-1:0] m;
    longint b, d, den;
    m = (reg_mode == MODE_ALIAS_HORIZONTAL) ? MODE_HORIZONTAL : reg_mode;
    col_cnt = '0;
    row_cnt = '0;
    col_len = (reg_bands == 0 || m == MODE_VERTICAL) ? '0
            : eff_dim(reg_width) / DIM_W'(reg_bands);
    row_len = (reg_bands == 0 || m == MODE_HORIZONTAL) ? '0
            : eff_dim(reg_height) / DIM_W'(reg_bands);
    col_mark = {1'b0, col_len};
    row_mark = {1'b0, row_len};
    den = longint'(reg_bands) * ((m == MODE_DIAGONAL) ? 2 : 1);
    for (int k = 0; k < 3; k++) begin
      b = longint'(reg_begin[(2-k)*8 +: 8]);
      d = longint'(reg_end[(2-k)*8 +: 8]) - b;
      step_inc[k] = (den == 0) ? 0 : (d * (longint'(1) << FRAC)) / den;
      row_base[k] = b * (longint'(1) << FRAC);
      acc[k] = row_base[k];
    end
  endfunction

  function automatic pixel_t predict_pixel(logic start);
    pixel_t px;
    logic [DIM_W:0] col_next, row_next;
    if (start) load_frame();
    col_next = {1'b0, col_cnt} + (DIM_W+1)'(1);
    row_next = {1'b0, row_cnt} + (DIM_W+1)'(1);
    if (col_next == col_mark) begin
      col_mark = col_mark + {1'b0, col_len};
      foreach (acc[k]) acc[k] += step_inc[k];
    end
    px.red   = sat_channel(acc[0]);
    px.green = sat_channel(acc[1]);
    px.blue  = sat_channel(acc[2]);
    px.eol   = col_next >= {1'b0, eff_dim(reg_width)};
    px.eof   = px.eol && row_next >= {1'b0, eff_dim(reg_height)};
    if (px.eof) begin
      load_frame();
    end else if (px.eol) begin
      if (row_next == row_mark) begin
        row_mark = row_mark + {1'b0, row_len};
        foreach (row_base[k]) row_base[k] += step_inc[k];
      end
      foreach (acc[k]) acc[k] = row_base[k];
      col_mark = {1'b0, col_len};
      col_cnt  = '0;
      row_cnt  = row_next[DIM_W-1:0];
    end else begin
      col_cnt = col_next[DIM_W-1:0];
    end
    return px;
  endfunction

  function automatic int unsigned pick_gap(bit allow_zero);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(allow_zero ? 0 : 1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return COLOR_BLACK;
    if (r < 20) return COLOR_WHITE;
    return COLOR_W'($urandom_range(0, COLOR_WHITE));
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim(int unsigned typical);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 88) return DIM_W'($urandom_range(1, typical));
    if (r < 93) return '0;
    return DIM_W'($urandom_range(0, DIM_ALL_ONES));
  endfunction

  function automatic logic [BAND_W-1:0] pick_bands();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 18) return BAND_W'($urandom_range(0, 255));
    return BAND_W'($urandom_range(1, 12));
  endfunction

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_wdata    <= data;
    @(posedge clk);
    case (idx)
      REG_BEGIN_COLOR:   reg_begin  = data[COLOR_W-1:0];
      REG_END_COLOR:     reg_end    = data[COLOR_W-1:0];
      REG_FRAME_WIDTH:   reg_width  = data[DIM_W-1:0];
      REG_FRAME_HEIGHT:  reg_height = data[DIM_W-1:0];
      REG_BAND_COUNT:    reg_bands  = data[BAND_W-1:0];
      REG_GRADIENT_MODE: reg_mode   = data[MODE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [COLOR_W-1:0] c_begin, input logic [COLOR_W-1:0] c_end,
                              input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input logic [BAND_W-1:0] bands, input logic [MODE_W-1:0] mode);
    write_reg(REG_BEGIN_COLOR, CFG_DATA_W'(c_begin));
    write_reg(REG_END_COLOR, CFG_DATA_W'(c_end));
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_BAND_COUNT, CFG_DATA_W'(bands));
    write_reg(REG_GRADIENT_MODE, CFG_DATA_W'(mode));
    cfg_write_en <= 1'b0;
  endtask

  // drain all pixels, then let a frame setup started by the last pixel finish
  task automatic settle_block();
    tick_ch.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETUP_GUARD) @(posedge clk);
  endtask

  task automatic send_tick(input logic start);
    int unsigned gap;
    gap = (src_jitter && $urandom_range(0, 99) < 35) ? pick_gap(1'b0) : 0;
    if (gap != 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid       <= 1'b1;
    tick_ch.frame_start <= start;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    expected_pixels.push_back(predict_pixel(start));
  endtask

  task automatic check_field(input string name, input logic [CHAN_W-1:0] want,
                             input logic [CHAN_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected pixel rgb %0d %0d %0d eol %0d eof %0d", $time,
                 pix_ch.pixel_red, pix_ch.pixel_green, pix_ch.pixel_blue,
                 pix_ch.end_of_line, pix_ch.end_of_frame);
      end else begin
        want = expected_pixels.pop_front();
        check_field("red", want.red, pix_ch.pixel_red);
        check_field("green", want.green, pix_ch.pixel_green);
        check_field("blue", want.blue, pix_ch.pixel_blue);
        check_field("end_of_line", CHAN_W'(want.eol), CHAN_W'(pix_ch.end_of_line));
        check_field("end_of_frame", CHAN_W'(want.eof), CHAN_W'(pix_ch.end_of_frame));
      end
    end
  end

  initial begin : pixel_sink
    int unsigned held;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        hold_sink = 1'b0;
        pix_ch.ready <= 1'b0;
        held = 0;
        while (held < SINK_HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
        pix_ch.ready <= 1'b1;
      end else if (sink_jitter && $urandom_range(0, 99) < 25) begin
        pix_ch.ready <= 1'b0;
        repeat (pick_gap(1'b0)) @(posedge clk);
        pix_ch.ready <= 1'b1;
      end else begin
        pix_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // zero state: black pixels on the default raster
  task automatic test_reset_raster();
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  // more steps than bands, climbing past 255; last tick free-runs into the next frame
  task automatic test_horizontal_overshoot();
    settle_block();
    program_regs(COLOR_BLACK, COLOR_WHITE, 13'd4, 13'd1, 8'd3, MODE_HORIZONTAL);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
  endtask

  // falling color that undershoots zero
  task automatic test_vertical_undershoot();
    settle_block();
    program_regs(COLOR_WHITE, COLOR_BLACK, 13'd1, 13'd5, 8'd3, MODE_VERTICAL);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
  endtask

  task automatic test_diagonal_bands();
    settle_block();
    program_regs(24'h1080F0, 24'hF02010, 13'd2, 13'd2, 8'd2, MODE_DIAGONAL);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
  endtask

  // mode alias, zero bands, zero size
  task automatic test_degenerate_settings();
    settle_block();
    program_regs(pick_color(), pick_color(), '0, '0, '0, MODE_ALIAS_HORIZONTAL);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic test_size_clamp();
    settle_block();
    program_regs(COLOR_BLACK, COLOR_WHITE, DIM_W'(DIM_ALL_ONES), DIM_W'(DIM_ALL_ONES),
                 8'd255, MODE_DIAGONAL);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  task automatic test_backpressure();
    settle_block();
    program_regs(pick_color(), pick_color(), 13'd8, 13'd4, 8'd4, MODE_DIAGONAL);
    src_jitter  = 1'b0;
    sink_jitter = 1'b0;
    hold_sink   = 1'b1;
    send_tick(1'b1);
    repeat (39) send_tick(1'b0);
    settle_block();
    src_jitter  = 1'b1;
    sink_jitter = 1'b1;
  endtask

  task automatic test_random_frames();
    int unsigned sent, area, count;
    logic [DIM_W-1:0] w, h;
    bit resume;
    sent = 0;
    while (sent < RANDOM_TICKS) begin
      settle_block();
      w = pick_dim(10);
      h = pick_dim(6);
      program_regs(pick_color(), pick_color(), w, h, pick_bands(),
                   MODE_W'($urandom_range(0, 3)));
      src_jitter  = ($urandom_range(0, 3) != 0);
      sink_jitter = ($urandom_range(0, 3) != 0);
      // occasionally keep the running raster across the size change
      resume = ($urandom_range(0, 7) == 0);
      area = 32'(eff_dim(w)) * 32'(eff_dim(h));
      count = (area <= 64) ? area * $urandom_range(1, 2) + $urandom_range(0, area)
                           : $urandom_range(8, 60);
      for (int i = 0; i < count; i++)
        send_tick((i == 0 && !resume) || $urandom_range(0, 39) == 0);
      sent += count;
    end
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_write_en        = 1'b0;
    cfg_index           = REG_BEGIN_COLOR;
    cfg_wdata           = '0;
    tick_ch.valid       = 1'b0;
    tick_ch.frame_start = 1'b0;
    pix_ch.ready        = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_raster();
    test_horizontal_overshoot();
    test_vertical_undershoot();
    test_diagonal_bands();
    test_degenerate_settings();
    test_size_clamp();
    test_backpressure();
    test_random_frames();

    settle_block();
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* stepped_color_gradient_generator_unit.f */
hw/rtl/scgg_pkg.sv
hw/rtl/scgg_stream_if.sv
hw/rtl/scgg_div.sv
hw/rtl/scgg_raster.sv
hw/rtl/stepped_color_gradient_generator_unit.sv
hw/rtl/scgg_checker.sv
sim/tb_stepped_color_gradient_generator_unit.sv
